### rtl/core/fud_pkg.sv
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types, constants and the hex digit helper function of the file URI percent decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

  localparam int PREFIX_LEN = 7;
  localparam int PRE_W      = 3;

  localparam logic [7:0] PREFIX_CHARS [PREFIX_LEN] = '{
    8'h66, 8'h69, 8'h6c, 8'h65, 8'h3a, 8'h2f, 8'h2f
  };
  localparam logic [PRE_W-1:0] PRE_LAST     = PRE_W'(PREFIX_LEN - 1);
  localparam logic [PRE_W-1:0] PRE_FULL     = PRE_W'(PREFIX_LEN);
  localparam logic [7:0]       PERCENT_CHAR = 8'h25;

  localparam logic [15:0] MAX_LENGTH_RST = 16'd255;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    CM_MATCH,
    CM_DECODE,
    CM_RAW
  } copy_mode_e;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PCT,
    ESC_DIGIT
  } esc_phase_e;

  typedef enum logic [1:0] {
    PM_DECODED,
    PM_RAW,
    PM_NONE
  } path_mode_e;

  // One command describes every result caused by one input byte: a burst of
  // prefix bytes, an optional data byte, and the end marker on the last one.
  typedef struct packed {
    logic [PRE_W-1:0] npre;
    logic             has_byte;
    logic [7:0]       data;
    path_mode_e       data_mode;
    logic             last;
    path_mode_e       end_mode;
  } fud_cmd_t;

  // Hex digit value; bytes outside the digit ranges use the letter arithmetic
  // and wrap modulo 256.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
    end else begin
      v = c - 8'h41 + 8'd10;
    end
    return v;
  endfunction

endpackage

### rtl/core/fud_in_if.sv
// ----------------------------------------------------------------------------
// fud_in_if
// Request channel carrying URI bytes with a last marker.
// ----------------------------------------------------------------------------
interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] uri_byte;
  logic       is_last;

  modport source (output valid, uri_byte, is_last, input ready);
  modport sink   (input valid, uri_byte, is_last, output ready);
endinterface

### rtl/core/fud_out_if.sv
// ----------------------------------------------------------------------------
// fud_out_if
// Request channel carrying decoded path bytes and the end marker.
// ----------------------------------------------------------------------------
interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_path;
  logic [1:0] path_mode;

  modport source (output valid, out_byte, byte_valid, end_of_path, path_mode, input ready);
  modport sink   (input valid, out_byte, byte_valid, end_of_path, path_mode, output ready);
endinterface

### rtl/core/fud_front.sv
// ----------------------------------------------------------------------------
// fud_front
// Accepts URI bytes, tracks prefix match and escapes, and issues commands.
// ----------------------------------------------------------------------------
module fud_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      max_length_i,
  fud_in_if.sink           in_i,
  output logic             push_valid_o,
  output fud_pkg::fud_cmd_t push_cmd_o,
  input  logic             push_ready_i
);
  import fud_pkg::*;

  copy_mode_e        copy_mode_q, copy_mode_d;
  esc_phase_e        esc_q, esc_d;
  logic [PRE_W-1:0]  pre_cnt_q, pre_cnt_d;
  logic [15:0]       position_q, position_d;
  logic [7:0]        first_digit_q, first_digit_d;

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic       in_range;
  logic       pre_hit;
  logic       pre_done;
  logic       pre_fail;
  logic       is_pct;
  logic       decoded_after;
  logic [7:0] hv_hi;
  logic [7:0] hv_lo;
  fud_cmd_t   cmd;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.uri_byte;
  assign last       = in_i.is_last;

  assign in_range = position_q < max_length_i;
  assign is_pct   = (b == PERCENT_CHAR);
  assign pre_hit  = (pre_cnt_q < PRE_FULL) && (b == PREFIX_CHARS[pre_cnt_q]);
  assign pre_done = pre_hit && (pre_cnt_q == PRE_LAST);
  assign pre_fail = !pre_done && (!pre_hit || last);

  assign hv_hi = hex_value(first_digit_q);
  assign hv_lo = hex_value(b);

  assign decoded_after = (copy_mode_q == CM_DECODE) ||
                         ((copy_mode_q == CM_MATCH) && pre_done);

  // Next state.
  always_comb begin
    copy_mode_d   = copy_mode_q;
    esc_d         = esc_q;
    pre_cnt_d     = pre_cnt_q;
    position_d    = position_q;
    first_digit_d = first_digit_q;
    if (accept) begin
      unique case (copy_mode_q)
        CM_MATCH: begin
          if (pre_done) begin
            copy_mode_d = CM_DECODE;
            pre_cnt_d   = PRE_FULL;
          end else if (pre_hit && !last) begin
            pre_cnt_d = pre_cnt_q + 3'd1;
          end else begin
            copy_mode_d = CM_RAW;
          end
        end
        CM_DECODE: begin
          unique case (esc_q)
            ESC_PCT: begin
              if (last) begin
                esc_d = ESC_NONE;
              end else begin
                first_digit_d = b;
                esc_d         = ESC_DIGIT;
              end
            end
            ESC_DIGIT: esc_d = ESC_NONE;
            default: begin
              if (in_range && is_pct && !last) begin
                esc_d = ESC_PCT;
              end
            end
          endcase
        end
        default: ;
      endcase
      if (position_q != POS_MAX) begin
        position_d = position_q + 16'd1;
      end
      if (last) begin
        copy_mode_d   = CM_MATCH;
        esc_d         = ESC_NONE;
        pre_cnt_d     = '0;
        position_d    = '0;
        first_digit_d = '0;
      end
    end
  end

  // Command for the back end.
  always_comb begin
    cmd           = '0;
    cmd.data      = b;
    cmd.last      = last;
    cmd.data_mode = PM_DECODED;
    cmd.end_mode  = decoded_after ? PM_DECODED :
                    ((max_length_i == 16'd0) ? PM_NONE : PM_RAW);
    unique case (copy_mode_q)
      CM_MATCH: begin
        cmd.data_mode = PM_RAW;
        if (pre_fail) begin
          // Flush the matched prefix bytes that lie below the length limit.
          cmd.npre     = (max_length_i < {13'd0, pre_cnt_q}) ? max_length_i[PRE_W-1:0]
                                                              : pre_cnt_q;
          cmd.has_byte = in_range;
        end
      end
      CM_DECODE: begin
        unique case (esc_q)
          ESC_PCT:   cmd.has_byte = last && in_range && !is_pct;
          ESC_DIGIT: begin
            cmd.has_byte = 1'b1;
            cmd.data     = {hv_hi[3:0], 4'd0} | hv_lo;
          end
          default:   cmd.has_byte = in_range && !is_pct;
        endcase
      end
      default: begin
        cmd.data_mode = PM_RAW;
        cmd.has_byte  = in_range;
      end
    endcase
  end

  assign push_valid_o = accept && ((cmd.npre != '0) || cmd.has_byte || last);
  assign push_cmd_o   = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_mode_q   <= CM_MATCH;
      esc_q         <= ESC_NONE;
      pre_cnt_q     <= '0;
      position_q    <= '0;
      first_digit_q <= '0;
    end else begin
      copy_mode_q   <= copy_mode_d;
      esc_q         <= esc_d;
      pre_cnt_q     <= pre_cnt_d;
      position_q    <= position_d;
      first_digit_q <= first_digit_d;
    end
  end

  a_match_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (copy_mode_q == CM_MATCH) |-> (pre_cnt_q < PRE_FULL))
    else $error("prefix count out of range while matching");

  a_esc_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (esc_q != ESC_NONE) |-> (copy_mode_q == CM_DECODE))
    else $error("escape pending outside decode mode");

endmodule

### rtl/core/fud_queue.sv
// ----------------------------------------------------------------------------
// fud_queue
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module fud_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  fud_pkg::fud_cmd_t push_cmd_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output fud_pkg::fud_cmd_t pop_cmd_o,
  input  logic              pop_ready_i
);
  import fud_pkg::*;

  fud_cmd_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 3'd1;
    end else if (pop && !push) begin
      count_d = count_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("command queue count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != QCNT_W'(QDEPTH)) |-> (QPTR_W'(wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule

### rtl/core/fud_back.sv
// ----------------------------------------------------------------------------
// fud_back
// Expands queued commands into path bytes, one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module fud_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  fud_pkg::fud_cmd_t pop_cmd_i,
  output logic              pop_ready_o,
  fud_out_if.source         out_o
);
  import fud_pkg::*;

  logic [PRE_W-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  logic             byte_valid_q;
  logic             end_q;
  path_mode_e       mode_q;

  logic [PRE_W-1:0] total;
  logic             last_step;
  logic             load;
  logic             take;
  logic [7:0]       s_byte;
  logic             s_valid;
  path_mode_e       s_mode;
  logic             s_end;

  assign total     = pop_cmd_i.npre + {2'd0, pop_cmd_i.has_byte};
  assign last_step = (total == '0) || (step_q == total - 3'd1);
  assign load      = !out_valid_q || out_o.ready;
  assign take      = pop_valid_i && load;
  assign pop_ready_o = load && last_step;

  // Prefix bytes come first, then the data byte; a command with neither
  // yields the bare end marker.
  always_comb begin
    if (step_q < pop_cmd_i.npre) begin
      s_byte  = PREFIX_CHARS[step_q];
      s_valid = 1'b1;
      s_mode  = PM_RAW;
    end else if (pop_cmd_i.has_byte) begin
      s_byte  = pop_cmd_i.data;
      s_valid = 1'b1;
      s_mode  = pop_cmd_i.data_mode;
    end else begin
      s_byte  = '0;
      s_valid = 1'b0;
      s_mode  = pop_cmd_i.data_mode;
    end
    s_end = pop_cmd_i.last && last_step;
    if (s_end) begin
      s_mode = pop_cmd_i.end_mode;
    end
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = pop_valid_i;
    end
    if (take) begin
      step_d = last_step ? '0 : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q   <= s_byte;
      byte_valid_q <= s_valid;
      end_q        <= s_end;
      mode_q       <= s_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.byte_valid  = byte_valid_q;
  assign out_o.end_of_path = end_q;
  assign out_o.path_mode   = mode_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < PRE_FULL)
    else $error("step counter out of range");

  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !byte_valid_q) |-> end_q)
    else $error("result without a byte that does not end the path");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_valid_i |-> (step_q == '0))
    else $error("step counter busy with no command");

endmodule

### rtl/core/file_uri_percent_decoder.sv
// The first result of a request passes through the command queue and then the back end's output register.
// Throughput: one URI byte per cycle while the four-entry command queue has room; each byte
// yields at most one result, except a failed "file://" match, which flushes up to seven results,
// one per cycle from the back end's step counter while the output is not stalled.
// Reset (asynchronous, active low) returns to prefix matching at index zero and sets
// max_length to 255.
// ----------------------------------------------------------------------------
// file_uri_percent_decoder
// Strips a "file://" prefix and percent-decodes the path, else copies raw.
// ----------------------------------------------------------------------------
module file_uri_percent_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  fud_in_if.sink      uri_i,
  fud_out_if.source   path_o
);
  import fud_pkg::*;

  logic [15:0] max_length_q;
  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  fud_cmd_t    push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  fud_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_length_i (max_length_q),
    .in_i         (uri_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  fud_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  fud_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .out_o       (path_o)
  );

endmodule

### tb/sv/file_uri_percent_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// file_uri_percent_decoder_test
// Streams URIs into the decoder across several max_length settings and checks
// every path result against a cycle-free prediction of the decoder.
// ----------------------------------------------------------------------------
module file_uri_percent_decoder_test;
  import fud_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 52;
  localparam int          IDLE_PCT    = 22;
  localparam int          PRINT_CAP   = 50;
  localparam logic [15:0] LEN_NONE    = 16'd0;
  localparam logic [15:0] LEN_FULL    = 16'hFFFF;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eop;
    path_mode_e mode;
  } path_res_t;

  class path_scoreboard;
    path_res_t   expected[$];
    int          n_errors;
    logic [15:0] max_len;
    logic [15:0] pos;
    logic [2:0]  matched;
    copy_mode_e  mode;
    esc_phase_e  esc;
    logic [7:0]  held_digit;

    function new();
      n_errors = 0;
      max_len  = MAX_LENGTH_RST;
      clear_uri();
    endfunction

    function void clear_uri();
      pos        = '0;
      matched    = '0;
      mode       = CM_MATCH;
      esc        = ESC_NONE;
      held_digit = '0;
    endfunction

    // Anything that is not a digit or a lower-case hex letter goes through the
    // upper-case letter arithmetic and wraps.
    function logic [7:0] digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") begin
        return c - "0";
      end
      if (c >= "a" && c <= "f") begin
        return c - "a" + 8'd10;
      end
      return c - "A" + 8'd10;
    endfunction

    function void add_byte(logic [7:0] b, path_mode_e m);
      path_res_t r;
      r.data  = b;
      r.valid = 1'b1;
      r.eop   = 1'b0;
      r.mode  = m;
      expected.push_back(r);
    endfunction

    function void note_request(logic [7:0] b, logic last);
      logic       in_rng;
      logic       hit;
      logic [7:0] decoded;
      int         n0;
      path_mode_e end_mode;
      path_res_t  r;
      in_rng = pos < max_len;
      n0     = expected.size();
      case (mode)
        CM_MATCH: begin
          hit = b == PREFIX_CHARS[matched];
          if (hit && matched == PRE_LAST) begin
            mode    = CM_DECODE;
            matched = PRE_FULL;
          end else if (hit && !last) begin
            matched = matched + 3'd1;
          end else begin
            // Give back the part of the prefix seen so far, then the byte itself.
            mode = CM_RAW;
            for (int k = 0; k < matched; k++) begin
              if (k < max_len) begin
                add_byte(PREFIX_CHARS[k], PM_RAW);
              end
            end
            if (in_rng) begin
              add_byte(b, PM_RAW);
            end
          end
        end
        CM_DECODE: begin
          case (esc)
            ESC_PCT: begin
              if (last) begin
                if (in_rng && b != PERCENT_CHAR) begin
                  add_byte(b, PM_DECODED);
                end
                esc = ESC_NONE;
              end else begin
                held_digit = b;
                esc        = ESC_DIGIT;
              end
            end
            ESC_DIGIT: begin
              decoded = (digit_value(held_digit) << 4) | digit_value(b);
              add_byte(decoded, PM_DECODED);
              esc = ESC_NONE;
            end
            default: begin
              if (in_rng) begin
                if (b == PERCENT_CHAR) begin
                  if (!last) begin
                    esc = ESC_PCT;
                  end
                end else begin
                  add_byte(b, PM_DECODED);
                end
              end
            end
          endcase
        end
        default: begin
          if (in_rng) begin
            add_byte(b, PM_RAW);
          end
        end
      endcase
      if (pos != POS_MAX) begin
        pos = pos + 16'd1;
      end
      if (last) begin
        if (mode == CM_DECODE) begin
          end_mode = PM_DECODED;
        end else if (max_len == LEN_NONE) begin
          end_mode = PM_NONE;
        end else begin
          end_mode = PM_RAW;
        end
        if (expected.size() == n0) begin
          r = '{data: 8'h00, valid: 1'b0, eop: 1'b1, mode: end_mode};
        end else begin
          r      = expected.pop_back();
          r.eop  = 1'b1;
          r.mode = end_mode;
        end
        expected.push_back(r);
        clear_uri();
      end
    endfunction

    task report(string msg);
      n_errors++;
      if (n_errors <= PRINT_CAP) begin
        $display("%0t mismatch: %s", $realtime, msg);
      end
    endtask

    task check_result(path_res_t got);
      path_res_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result, byte %02h", got.data));
        return;
      end
      want = expected.pop_front();
      if (got.data !== want.data) begin
        report($sformatf("out_byte %02h, expected %02h", got.data, want.data));
      end
      if (got.valid !== want.valid) begin
        report($sformatf("byte_valid %b, expected %b", got.valid, want.valid));
      end
      if (got.eop !== want.eop) begin
        report($sformatf("end_of_path %b, expected %b", got.eop, want.eop));
      end
      if (got.mode !== want.mode) begin
        report($sformatf("path_mode %0d, expected %0d", got.mode, want.mode));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  bit          steady;
  int          stall_cycles;
  string       hex_digits = "0123456789abcdefABCDEF";

  path_scoreboard sb = new();

  fud_in_if  uri_ch ();
  fud_out_if path_ch ();

  file_uri_percent_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .uri_i      (uri_ch),
    .path_o     (path_ch)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Result side: random back-pressure, decided at the falling edge.
  initial begin
    path_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      path_ch.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && path_ch.valid && path_ch.ready) begin
      sb.check_result('{data: path_ch.out_byte, valid: path_ch.byte_valid,
                        eop: path_ch.end_of_path,
                        mode: path_mode_e'(path_ch.path_mode)});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (uri_ch.valid && uri_ch.ready) || (path_ch.valid && path_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic byte_q_t text_bytes(string t);
    byte_q_t s;
    for (int i = 0; i < t.len(); i++) begin
      s.push_back(t[i]);
    end
    return s;
  endfunction

  function automatic logic [7:0] random_char();
    if ($urandom_range(0, 9) == 0) begin
      return PERCENT_CHAR;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed file URIs with escapes, then broken prefixes and noise.
  function automatic byte_q_t build_uri();
    byte_q_t s;
    int      kind;
    int      len;
    int      cut;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      for (int k = 0; k < PREFIX_LEN; k++) begin
        s.push_back(PREFIX_CHARS[k]);
      end
      len = PREFIX_LEN + $urandom_range(0, 12);
      while (s.size() < len) begin
        if ($urandom_range(0, 9) < 3) begin
          s.push_back(PERCENT_CHAR);
          repeat (2) begin
            if ($urandom_range(0, 3) == 0) begin
              s.push_back(random_char());
            end else begin
              s.push_back(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
            end
          end
        end else begin
          s.push_back(random_char());
        end
      end
    end else if (kind < 85) begin
      cut = $urandom_range(1, PREFIX_LEN - 1);
      for (int k = 0; k < cut; k++) begin
        s.push_back(PREFIX_CHARS[k]);
      end
      // Some stop right inside the prefix, the rest go astray after it.
      if ($urandom_range(0, 2) != 0) begin
        s.push_back(random_char());
        len = s.size() + $urandom_range(0, 8);
        while (s.size() < len) begin
          s.push_back(random_char());
        end
      end
    end else begin
      len = $urandom_range(1, 10);
      while (s.size() < len) begin
        s.push_back(random_char());
      end
    end
    return s;
  endfunction

  // Entered and left at a falling edge; valid stays up between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      uri_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    uri_ch.valid    <= 1'b1;
    uri_ch.uri_byte <= b;
    uri_ch.is_last  <= last;
    @(posedge clk_i);
    while (!uri_ch.ready) begin
      @(posedge clk_i);
    end
    sb.note_request(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_uri(input byte_q_t s);
    for (int i = 0; i < s.size(); i++) begin
      send_byte(s[i], i == s.size() - 1);
    end
  endtask

  // The register only changes once every pending result has drained.
  task automatic set_max_length(input logic [15:0] v);
    uri_ch.valid <= 1'b0;
    while (sb.expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    sb.max_len = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] length_limits[$];
    byte_q_t     s;
    int          sent;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    uri_ch.valid    = 1'b0;
    uri_ch.uri_byte = '0;
    uri_ch.is_last  = 1'b0;
    steady          = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Exact prefix, prefix cut short by the last byte, extreme bytes in raw mode,
    // and escapes with non-hex digits ending on a lone percent sign.
    send_uri(text_bytes("file://"));
    send_uri(text_bytes("fil"));
    send_uri('{8'h00, 8'hff});
    send_uri(text_bytes("file://%zf%A9%"));

    length_limits = '{MAX_LENGTH_RST, LEN_NONE, LEN_FULL, 16'd1, 16'd7, 16'd9,
                      16'($urandom_range(2, 16)), 16'($urandom_range(0, 65535))};
    foreach (length_limits[p]) begin
      set_max_length(length_limits[p]);
      steady = length_limits[p] == LEN_FULL;
      sent   = 0;
      while (sent < PHASE_ITEMS) begin
        s = build_uri();
        send_uri(s);
        sent += s.size();
      end
      steady = 1'b0;
    end

    uri_ch.valid <= 1'b0;
    while (sb.expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/fud_pkg.sv
rtl/core/fud_in_if.sv
rtl/core/fud_out_if.sv
rtl/core/fud_front.sv
rtl/core/fud_queue.sv
rtl/core/fud_back.sv
rtl/core/file_uri_percent_decoder.sv
tb/sv/file_uri_percent_decoder_test.sv
